FILE: src/dek_pkg.sv
// Shared types and constants for the dictionary entry key extractor.
package dek_pkg;

    localparam int KEY_W = 12;

    localparam logic [1:0] MODE_HEADWORD = 2'd0;
    localparam logic [1:0] MODE_READING  = 2'd1;
    localparam logic [1:0] MODE_GLOSS    = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_PAREN = 3'd2,
        PH_GAP   = 3'd3,
        PH_TEXT  = 3'd4
    } gloss_phase_t;

    typedef struct packed {
        gloss_phase_t phase;
        logic         bracket_seen;
        logic         key_reported;
    } scan_flags_t;

    localparam scan_flags_t FLAGS_CLEAR = '{phase: PH_IDLE, bracket_seen: 1'b0,
                                           key_reported: 1'b0};

endpackage

FILE: src/dictionary_entry_key_extractor_unit.sv
// Dictionary entry key extractor: byte -> input register -> key output register -> key.
// Throughput: one byte per cycle while key output is not stalled; entry state updates as a
// byte leaves the input register. A stalled key output holds it there and drops entry_ready.
// Reset: mode headword, entry state cleared, both pipeline registers empty.
// A key_mode write clears the entry state.
module dictionary_entry_key_extractor_unit #(
    parameter int MAX_ENTRY_BYTES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        key_mode_we,
    input  logic [1:0]                  key_mode,
    input  logic                        entry_valid,
    output logic                        entry_ready,
    input  logic [7:0]                  entry_byte,
    input  logic                        last_byte,
    output logic                        key_valid,
    input  logic                        key_ready,
    output logic [dek_pkg::KEY_W-1:0]   key_offset,
    output logic [dek_pkg::KEY_W-1:0]   key_length
);
    import dek_pkg::*;

    localparam int POS_W = $clog2(MAX_ENTRY_BYTES + 1);

    logic [1:0]         mode_reg;
    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   span_reg;
    scan_flags_t        flags_reg;
    logic               out_valid_reg;
    logic [KEY_W-1:0]   offset_reg;
    logic [KEY_W-1:0]   length_reg;

    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   span_next;
    scan_flags_t        flags_next;
    logic               emit;
    logic [KEY_W-1:0]   emit_offset;
    logic [KEY_W-1:0]   emit_length;
    logic               advance;
    logic               step;

    assign advance     = !out_valid_reg || key_ready;
    assign step        = in_valid_reg && advance;
    assign entry_ready = !in_valid_reg || advance;

    dek_scanner #(
        .MAX_ENTRY_BYTES(MAX_ENTRY_BYTES),
        .POS_W          (POS_W)
    ) u_scanner (
        .key_mode   (mode_reg),
        .entry_byte (byte_reg),
        .last_byte  (last_reg),
        .pos        (pos_reg),
        .span       (span_reg),
        .flags      (flags_reg),
        .pos_next   (pos_next),
        .span_next  (span_next),
        .flags_next (flags_next),
        .emit       (emit),
        .emit_offset(emit_offset),
        .emit_length(emit_length)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HEADWORD;
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            span_reg      <= '0;
            flags_reg     <= FLAGS_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry_ready)
                in_valid_reg <= entry_valid;

            if (key_mode_we)
            begin
                mode_reg  <= key_mode;
                pos_reg   <= '0;
                span_reg  <= '0;
                flags_reg <= FLAGS_CLEAR;
            end
            else if (step)
            begin
                pos_reg   <= pos_next;
                span_reg  <= span_next;
                flags_reg <= flags_next;
            end

            if (step && emit)
                out_valid_reg <= 1'b1;
            else if (key_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_valid && entry_ready)
        begin
            byte_reg <= entry_byte;
            last_reg <= last_byte;
        end
        if (step && emit)
        begin
            offset_reg <= emit_offset;
            length_reg <= emit_length;
        end
    end

    assign key_valid  = out_valid_reg;
    assign key_offset = offset_reg;
    assign key_length = length_reg;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ENTRY_BYTES);

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_LIMIT)
        else $error("byte position ran past the entry limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        key_mode_we |=> (pos_reg == '0) && (flags_reg == FLAGS_CLEAR))
        else $error("mode write did not clear entry state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_reg.key_reported) |-> out_valid_reg)
        else $error("key marked reported without a key transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        !entry_ready |-> (in_valid_reg && out_valid_reg && !key_ready))
        else $error("input stalled without a blocked key output");

endmodule

FILE: src/dek_scanner.sv
// Per-byte scan logic: next entry state and key span for one byte.
module dek_scanner #(
    parameter int MAX_ENTRY_BYTES = 4096,
    parameter int POS_W           = 13
) (
    input  logic [1:0]                  key_mode,
    input  logic [7:0]                  entry_byte,
    input  logic                        last_byte,
    input  logic [POS_W-1:0]            pos,
    input  logic [POS_W-1:0]            span,
    input  dek_pkg::scan_flags_t        flags,
    output logic [POS_W-1:0]            pos_next,
    output logic [POS_W-1:0]            span_next,
    output dek_pkg::scan_flags_t        flags_next,
    output logic                        emit,
    output logic [dek_pkg::KEY_W-1:0]   emit_offset,
    output logic [dek_pkg::KEY_W-1:0]   emit_length
);
    import dek_pkg::*;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ENTRY_BYTES);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

    logic in_range;
    logic reading_close;

    assign in_range      = (pos < POS_LIMIT);
    assign reading_close = ({1'b0, pos} >= ({1'b0, span} + {1'b0, POS_ONE}));

    always_comb
    begin
        pos_next    = pos;
        span_next   = span;
        flags_next  = flags;
        emit        = 1'b0;
        emit_offset = '0;
        emit_length = '0;

        if (in_range)
        begin
            pos_next = pos + POS_ONE;
            unique case (key_mode)
                MODE_HEADWORD:
                begin
                    if (!flags.key_reported && (pos != '0) && (entry_byte == CH_SPACE))
                    begin
                        emit                    = 1'b1;
                        emit_length             = KEY_W'(pos);
                        flags_next.key_reported = 1'b1;
                    end
                end
                MODE_READING:
                begin
                    if (!flags.key_reported)
                    begin
                        if (!flags.bracket_seen)
                        begin
                            if (entry_byte == CH_LBRACK)
                            begin
                                flags_next.bracket_seen = 1'b1;
                                span_next               = pos + POS_ONE;
                            end
                        end
                        else if ((entry_byte == CH_RBRACK) && reading_close)
                        begin
                            emit                    = 1'b1;
                            emit_offset             = KEY_W'(span);
                            emit_length             = KEY_W'(pos - span);
                            flags_next.key_reported = 1'b1;
                        end
                    end
                end
                MODE_GLOSS:
                begin
                    if (entry_byte == CH_SLASH)
                    begin
                        if (flags.phase == PH_TEXT)
                        begin
                            emit        = 1'b1;
                            emit_offset = KEY_W'(span);
                            emit_length = KEY_W'(pos - span);
                        end
                        else if (flags.phase != PH_IDLE)
                        begin
                            emit        = 1'b1;
                            emit_offset = KEY_W'(pos);
                        end
                        flags_next.phase = PH_START;
                    end
                    else
                    begin
                        unique case (flags.phase) inside
                            PH_START, PH_GAP:
                            begin
                                if (entry_byte == CH_LPAREN)
                                    flags_next.phase = PH_PAREN;
                                else if (!((flags.phase == PH_GAP) && (entry_byte == CH_SPACE)))
                                begin
                                    span_next        = pos;
                                    flags_next.phase = PH_TEXT;
                                end
                            end
                            PH_PAREN:
                            begin
                                if (entry_byte == CH_RPAREN)
                                    flags_next.phase = PH_GAP;
                            end
                            PH_TEXT, PH_IDLE:
                            begin
                                flags_next.phase = flags.phase;
                            end
                            default:
                            begin
                                flags_next.phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    flags_next = flags;
                end
            endcase
        end

        if (last_byte)
        begin
            pos_next   = '0;
            span_next  = '0;
            flags_next = FLAGS_CLEAR;
        end
    end

endmodule

FILE: bench/dictionary_entry_key_extractor_unit_tb.sv
// Self-checking testbench for the dictionary entry key extractor unit.
`timescale 1ns / 1ps

module dictionary_entry_key_extractor_unit_tb;

    import dek_pkg::*;

    localparam int         ENTRY_LIMIT = 4096;
    localparam int         DIR_ROWS    = 24;
    localparam int         PHASES      = 8;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key_off;
        logic [KEY_W-1:0] key_len;
    } key_span_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       data;
        logic             last;
        logic             typed;
        logic             has;
        logic [KEY_W-1:0] key_off;
        logic [KEY_W-1:0] key_len;
    } dir_row_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             key_mode_we = 1'b0;
    logic [1:0]       key_mode    = MODE_HEADWORD;
    logic             entry_valid = 1'b0;
    logic             entry_ready;
    logic [7:0]       entry_byte  = 8'h00;
    logic             last_byte   = 1'b0;
    logic             key_valid;
    logic             key_ready   = 1'b0;
    logic [KEY_W-1:0] key_offset;
    logic [KEY_W-1:0] key_length;

    key_span_t    pending_keys [$];
    key_span_t    seen_key;
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    logic [1:0]   scan_mode    = MODE_HEADWORD;
    int           scan_pos     = 0;
    int           span_from    = 0;
    gloss_phase_t gloss_state  = PH_IDLE;
    logic         bracket_open = 1'b0;
    logic         key_given    = 1'b0;

    logic [1:0] phase_modes [PHASES] = '{MODE_HEADWORD, MODE_READING, MODE_GLOSS,
                                         MODE_HEADWORD, MODE_READING, MODE_GLOSS,
                                         MODE_GLOSS, MODE_UNUSED};

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{MODE_HEADWORD, CH_SPACE,  1'b0, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_HEADWORD, "a",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_HEADWORD, CH_SPACE,  1'b0, 1'b1, 1'b1, 12'd0,  12'd2},
        '{MODE_HEADWORD, CH_SPACE,  1'b1, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_READING,  CH_LBRACK, 1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_READING,  CH_RBRACK, 1'b0, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_READING,  "k",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_READING,  CH_RBRACK, 1'b0, 1'b1, 1'b1, 12'd1,  12'd2},
        '{MODE_READING,  CH_RBRACK, 1'b1, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    "x",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_SLASH,  1'b0, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_LPAREN, 1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    "n",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_SLASH,  1'b0, 1'b1, 1'b1, 12'd4,  12'd0},
        '{MODE_GLOSS,    CH_LPAREN, 1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_RPAREN, 1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_SPACE,  1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    "d",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    "o",       1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_SLASH,  1'b0, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_GLOSS,    CH_SLASH,  1'b0, 1'b1, 1'b1, 12'd11, 12'd0},
        '{MODE_GLOSS,    8'hFF,     1'b1, 1'b0, 1'b0, 12'd0,  12'd0},
        '{MODE_UNUSED,   CH_SLASH,  1'b0, 1'b1, 1'b0, 12'd0,  12'd0},
        '{MODE_UNUSED,   CH_SLASH,  1'b1, 1'b1, 1'b0, 12'd0,  12'd0}
    };

    dictionary_entry_key_extractor_unit #(
        .MAX_ENTRY_BYTES(ENTRY_LIMIT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_mode_we(key_mode_we),
        .key_mode   (key_mode),
        .entry_valid(entry_valid),
        .entry_ready(entry_ready),
        .entry_byte (entry_byte),
        .last_byte  (last_byte),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_offset (key_offset),
        .key_length (key_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_scan();
        scan_pos     = 0;
        span_from    = 0;
        gloss_state  = PH_IDLE;
        bracket_open = 1'b0;
        key_given    = 1'b0;
    endfunction

    function automatic void scan_entry_byte(input logic [7:0] b, input logic l,
                                            output logic has, output key_span_t span);
        has  = 1'b0;
        span = '0;
        if (scan_pos < ENTRY_LIMIT)
        begin
            case (scan_mode)
                MODE_HEADWORD:
                begin
                    if (!key_given && scan_pos >= 1 && b == CH_SPACE)
                    begin
                        has          = 1'b1;
                        span.key_len = scan_pos[KEY_W-1:0];
                        key_given    = 1'b1;
                    end
                end
                MODE_READING:
                begin
                    if (!key_given)
                    begin
                        if (!bracket_open)
                        begin
                            if (b == CH_LBRACK)
                            begin
                                bracket_open = 1'b1;
                                span_from    = scan_pos + 1;
                            end
                        end
                        else if (b == CH_RBRACK && scan_pos >= span_from + 1)
                        begin
                            has          = 1'b1;
                            span.key_off = span_from[KEY_W-1:0];
                            span.key_len = 12'(scan_pos - span_from);
                            key_given    = 1'b1;
                        end
                    end
                end
                MODE_GLOSS:
                begin
                    if (b == CH_SLASH)
                    begin
                        if (gloss_state == PH_TEXT)
                        begin
                            has          = 1'b1;
                            span.key_off = span_from[KEY_W-1:0];
                            span.key_len = 12'(scan_pos - span_from);
                        end
                        else if (gloss_state != PH_IDLE)
                        begin
                            has          = 1'b1;
                            span.key_off = scan_pos[KEY_W-1:0];
                        end
                        gloss_state = PH_START;
                    end
                    else if (gloss_state == PH_START || gloss_state == PH_GAP)
                    begin
                        if (b == CH_LPAREN)
                            gloss_state = PH_PAREN;
                        else if (!(gloss_state == PH_GAP && b == CH_SPACE))
                        begin
                            span_from   = scan_pos;
                            gloss_state = PH_TEXT;
                        end
                    end
                    else if (gloss_state == PH_PAREN && b == CH_RPAREN)
                        gloss_state = PH_GAP;
                end
                default: ;
            endcase
            scan_pos++;
        end
        if (l)
            clear_scan();
    endfunction

    task automatic send_entry_byte(input logic [7:0] b, input logic l, input logic typed,
                                   input logic typed_has, input key_span_t typed_span);
        int        gap;
        logic      has;
        key_span_t span;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            entry_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry_valid <= 1'b1;
        entry_byte  <= b;
        last_byte   <= l;
        do @(posedge clk); while (!entry_ready);
        scan_entry_byte(b, l, has, span);
        if (typed)
        begin
            has  = typed_has;
            span = typed_span;
        end
        if (has)
            pending_keys.push_back(span);
    endtask

    task automatic settle_extractor(input int extra);
        entry_valid <= 1'b0;
        do @(posedge clk); while (pending_keys.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_key_mode(input logic [1:0] m);
        key_mode_we <= 1'b1;
        key_mode    <= m;
        @(posedge clk);
        key_mode_we <= 1'b0;
        scan_mode = m;
        clear_scan();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && key_valid && key_ready)
        begin
            if (pending_keys.size() == 0)
            begin
                $display("%0t: unexpected key, offset %0d length %0d",
                         $time, key_offset, key_length);
                mismatch_count++;
            end
            else
            begin
                seen_key = pending_keys.pop_front();
                if (seen_key.key_off !== key_offset)
                begin
                    $display("%0t: key_offset expected %0d actual %0d",
                             $time, seen_key.key_off, key_offset);
                    mismatch_count++;
                end
                if (seen_key.key_len !== key_length)
                begin
                    $display("%0t: key_length expected %0d actual %0d",
                             $time, seen_key.key_len, key_length);
                    mismatch_count++;
                end
            end
        end
        key_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("dictionary_entry_key_extractor_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        int         phase;
        int         sent;
        int         quota;
        int         len;
        int         i;
        int         r;
        logic       paused;
        logic [7:0] b;
        logic [1:0] cur_mode;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_mode = MODE_HEADWORD;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].mode != cur_mode)
            begin
                settle_extractor(8);
                set_key_mode(dir_rows[i].mode);
                cur_mode = dir_rows[i].mode;
            end
            send_entry_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                            dir_rows[i].has, {dir_rows[i].key_off, dir_rows[i].key_len});
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_extractor(8);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            set_key_mode(phase_modes[phase]);
            quota  = (phase_modes[phase] == MODE_UNUSED) ? 60 : 260;
            sent   = 0;
            paused = 1'b0;
            while (sent < quota)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = $urandom_range(1, 2);
                else if (r < 85)
                    len = $urandom_range(3, 24);
                else
                    len = $urandom_range(25, 120);
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 12)
                        b = CH_SPACE;
                    else if (r < 20)
                        b = CH_LBRACK;
                    else if (r < 28)
                        b = CH_RBRACK;
                    else if (r < 42)
                        b = CH_SLASH;
                    else if (r < 50)
                        b = CH_LPAREN;
                    else if (r < 58)
                        b = CH_RPAREN;
                    else
                        b = 8'($urandom_range(0, 255));
                    send_entry_byte(b, k == len - 1, 1'b0, 1'b0, '0);
                    sent++;
                end
                if (!paused && sent > quota / 2)
                begin
                    settle_extractor(0);
                    paused = 1'b1;
                end
            end
        end

        settle_extractor(8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_key_mode(MODE_HEADWORD);
        for (i = 0; i < ENTRY_LIMIT + 5; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SPACE)
                b = "a";
            if (i >= ENTRY_LIMIT - 1)
                b = CH_SPACE;
            send_entry_byte(b, i == ENTRY_LIMIT + 4, 1'b0, 1'b0, '0);
        end

        settle_extractor(8);
        set_key_mode(MODE_GLOSS);
        for (i = 0; i < ENTRY_LIMIT + 4; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SLASH)
                b = "g";
            if (i == 1)
                b = "k";
            if (i == 0 || i >= ENTRY_LIMIT - 2)
                b = CH_SLASH;
            send_entry_byte(b, i == ENTRY_LIMIT + 3, 1'b0, 1'b0, '0);
        end

        settle_extractor(8);
        if (mismatch_count == 0)
            $display("dictionary_entry_key_extractor_unit_tb: PASS");
        else
            $display("dictionary_entry_key_extractor_unit_tb: FAIL");
        $finish;
    end

endmodule
